### rtl/bbc_pkg.sv
// bbc_pkg: shared types, codes and the byte classifier of the bracket balance checker
// no dependencies
`default_nettype none

package bbc_pkg;

  localparam int StackDepthDefault    = 64;
  localparam int PositionWidthDefault = 16;
  localparam int OutPosWidth          = 16;

  localparam logic [7:0] CharOpenBrace    = 8'h7B;
  localparam logic [7:0] CharOpenParen    = 8'h28;
  localparam logic [7:0] CharOpenBracket  = 8'h5B;
  localparam logic [7:0] CharCloseBrace   = 8'h7D;
  localparam logic [7:0] CharCloseParen   = 8'h29;
  localparam logic [7:0] CharCloseBracket = 8'h5D;

  localparam logic [1:0] CodeBrace   = 2'd0;
  localparam logic [1:0] CodeParen   = 2'd1;
  localparam logic [1:0] CodeBracket = 2'd2;
  localparam logic [1:0] CodeNone    = 2'd3;

  localparam logic [1:0] VerdictBalanced = 2'd0;
  localparam logic [1:0] VerdictMismatch = 2'd1;
  localparam logic [1:0] VerdictUnclosed = 2'd2;
  localparam logic [1:0] VerdictOverflow = 2'd3;

  typedef struct packed {
    logic       is_open;
    logic [1:0] code;
  } sym_class_t;

  typedef struct packed {
    logic [1:0]             verdict;
    logic [OutPosWidth-1:0] fail_position;
  } result_t;

  function automatic sym_class_t classify(input logic [7:0] sym);
    sym_class_t c;
    c.is_open = 1'b0;
    c.code    = CodeNone;
    case (sym)
      CharOpenBrace: begin
        c.is_open = 1'b1;
        c.code    = CodeBrace;
      end
      CharOpenParen: begin
        c.is_open = 1'b1;
        c.code    = CodeParen;
      end
      CharOpenBracket: begin
        c.is_open = 1'b1;
        c.code    = CodeBracket;
      end
      CharCloseBrace:   c.code = CodeBrace;
      CharCloseParen:   c.code = CodeParen;
      CharCloseBracket: c.code = CodeBracket;
      default:          c.code = CodeNone;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/bracket_balance_checker.sv
// Bracket balance checker: takes one byte per cycle and gives one verdict per string. Openers
// push their expected closer onto a stack held in a synchronous memory, with the top entry in
// a register and the entry below it prefetched each cycle, so pushes and pops may follow each
// other without a bubble. The input stalls only while a verdict sits in the output register
// and is not taken. No clearing pass follows reset.
// depends on bbc_pkg and bbc_core
`default_nettype none

module bracket_balance_checker #(
  parameter int StackDepth = bbc_pkg::StackDepthDefault,
  parameter int PositionWidth = bbc_pkg::PositionWidthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  symbol,
  input  wire logic        last_symbol,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       verdict,
  output logic [15:0]      fail_position
);

  logic             acc;
  logic             res_valid;
  bbc_pkg::result_t res;

  assign in_ready = !out_valid || out_ready;
  assign acc      = in_valid && in_ready;

  bbc_core #(
    .StackDepth(StackDepth),
    .PositionWidth(PositionWidth)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .acc(acc),
    .symbol(symbol),
    .last_symbol(last_symbol),
    .res_valid(res_valid),
    .res(res)
  );

  // output transaction register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      verdict       <= res.verdict;
      fail_position <= res.fail_position;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !res_valid)
    else $error("verdict overwrote a pending transaction");

  a_balanced_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (verdict == bbc_pkg::VerdictBalanced) |-> (fail_position == 16'd0))
    else $error("balanced verdict with nonzero position");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(fail_position))
    else $error("stalled verdict changed");

endmodule

`default_nettype wire

### rtl/bbc_stack_mem.sv
// bbc_stack_mem: closer code stack storage, one write port and one registered read port
// no dependencies
`default_nettype none

module bbc_stack_mem #(
  parameter int Depth = 64,
  parameter int AddrWidth = 6
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AddrWidth-1:0] waddr,
  input  wire logic [1:0]           wdata,
  input  wire logic [AddrWidth-1:0] raddr,
  output logic      [1:0]           rdata
);

  logic [1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/bbc_core.sv
// bbc_core: per-byte stack control, position tracking and first-failure capture
// depends on bbc_pkg and bbc_stack_mem
`default_nettype none

module bbc_core #(
  parameter int StackDepth = bbc_pkg::StackDepthDefault,
  parameter int PositionWidth = bbc_pkg::PositionWidthDefault
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            acc,
  input  wire logic [7:0]      symbol,
  input  wire logic            last_symbol,
  output logic                 res_valid,
  output bbc_pkg::result_t     res
);

  localparam int AddrWidth  = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int CountWidth = $clog2(StackDepth + 1);

  logic [CountWidth-1:0]    count, count_next;
  logic [1:0]               top, top_next;
  logic [PositionWidth-1:0] pos, pos_next, pos_inc;
  logic                     fail_seen, fail_seen_next;
  logic [1:0]               fail_kind, fail_kind_next;
  logic [PositionWidth-1:0] fail_index, fail_index_next;

  logic                     we;
  logic [AddrWidth-1:0]     waddr, raddr;
  logic [1:0]               below;
  logic [CountWidth-1:0]    count_m2;
  bbc_pkg::sym_class_t      cls;
  logic [31:0]              pos_ext;
  logic [PositionWidth-1:0] res_pos;
  logic [1:0]               res_verdict;
  logic [15:0]              res_fail_pos;
  logic                     push_ok;

  bbc_stack_mem #(
    .Depth(StackDepth),
    .AddrWidth(AddrWidth)
  ) u_mem (
    .clk(clk),
    .we(we),
    .waddr(waddr),
    .wdata(cls.code),
    .raddr(raddr),
    .rdata(below)
  );

  assign cls     = bbc_pkg::classify(symbol);
  assign pos_inc = (pos == {PositionWidth{1'b1}}) ? pos : pos + 1'b1;
  assign waddr   = count[AddrWidth-1:0];
  assign push_ok = acc && !fail_seen && cls.is_open && (count < CountWidth'(StackDepth));
  assign we      = push_ok;

  // address of the entry below the top after this cycle's update
  assign count_m2 = count_next - CountWidth'(2);
  assign raddr    = count_m2[AddrWidth-1:0];

  always_comb begin
    count_next      = count;
    top_next        = top;
    pos_next        = pos;
    fail_seen_next  = fail_seen;
    fail_kind_next  = fail_kind;
    fail_index_next = fail_index;
    res_valid       = 1'b0;
    res_pos         = '0;
    res_verdict     = bbc_pkg::VerdictBalanced;
    if (acc) begin
      if (!fail_seen) begin
        if (cls.is_open) begin
          if (push_ok) begin
            count_next = count + 1'b1;
            top_next   = cls.code;
          end else begin
            fail_seen_next  = 1'b1;
            fail_kind_next  = bbc_pkg::VerdictOverflow;
            fail_index_next = pos;
          end
        end else if ((count != '0) && (cls.code == top)) begin
          count_next = count - 1'b1;
          top_next   = below;
        end else begin
          fail_seen_next  = 1'b1;
          fail_kind_next  = bbc_pkg::VerdictMismatch;
          fail_index_next = pos;
        end
      end
      if (!last_symbol) begin
        pos_next = pos_inc;
      end else begin
        res_valid = 1'b1;
        if (fail_seen_next) begin
          res_verdict = fail_kind_next;
          res_pos     = fail_index_next;
        end else if (count_next != '0) begin
          res_verdict = bbc_pkg::VerdictUnclosed;
          res_pos     = pos_inc;
        end
        count_next      = '0;
        pos_next        = '0;
        fail_seen_next  = 1'b0;
        fail_kind_next  = bbc_pkg::VerdictBalanced;
        fail_index_next = '0;
      end
    end
  end

  assign pos_ext      = 32'(res_pos);
  assign res_fail_pos = (pos_ext > 32'h0000_FFFF) ? 16'hFFFF : pos_ext[15:0];
  assign res          = {res_verdict, res_fail_pos};

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      pos        <= '0;
      fail_seen  <= 1'b0;
      fail_kind  <= bbc_pkg::VerdictBalanced;
      fail_index <= '0;
    end else begin
      count      <= count_next;
      pos        <= pos_next;
      fail_seen  <= fail_seen_next;
      fail_kind  <= fail_kind_next;
      fail_index <= fail_index_next;
    end
  end

  always_ff @(posedge clk) begin
    top <= top_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CountWidth'(StackDepth))
    else $error("stack count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push_ok && !last_symbol |=> (count == $past(count) + 1'b1) && (top == $past(cls.code)))
    else $error("push did not grow the stack");

  a_fail_sticky: assert property (@(posedge clk) disable iff (rst)
    fail_seen && !(acc && last_symbol) |=> fail_seen && $stable(fail_index) && $stable(count))
    else $error("failure state changed before end of string");

  a_fail_clears: assert property (@(posedge clk) disable iff (rst)
    acc && last_symbol |=> !fail_seen && (count == '0) && (pos == '0))
    else $error("state not cleared after verdict");

endmodule

`default_nettype wire
